// ----- rtl/bma_pkg.sv -----
`default_nettype none

package bma_pkg;

    // Fixed field widths
    localparam int SAMPLE_W       = 8;   // input sample and output average
    localparam int WIN_W          = 7;   // window size register and fill count
    localparam int MAX_WINDOW_DEF = 64;  // default history depth

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_UPDATE = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_DONE   = 4'b1000
    } bma_state_t;

endpackage

`default_nettype wire

// ----- rtl/boxcar_moving_average.sv -----
`default_nettype none
// A sample is accepted in IDLE, enters the running sum in UPDATE, is divided in DIV by the
//   bit-serial restoring divider, one quotient bit per cycle, and in DONE is written to the
//   output register once that has drained. The next sample is accepted only back in IDLE.
// A sample that does not complete a full window goes from UPDATE back to IDLE and yields nothing.
// Reset (aresetn, synchronous, active low): window = 1, sum, fill count and slot cleared.
//   History RAM is not cleared; only slots written since the last restart are ever used.

module boxcar_moving_average #(
    parameter int MAX_WINDOW = bma_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,

    // Configuration write channel: window size
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [bma_pkg::WIN_W-1:0]    cfg_data,     // [6:0] window_size

    // Sample input stream
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [bma_pkg::SAMPLE_W-1:0] s_tdata,      // [7:0] sample (signed)

    // Average output stream
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [bma_pkg::SAMPLE_W-1:0]      m_tdata       // [7:0] average (signed)
);

    import bma_pkg::*;

    // Derived widths
    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W  = SAMPLE_W + SLOT_W;                 // holds -128 * MAX_WINDOW .. 127 * MAX_WINDOW
    localparam int CW     = (SLOT_W + 1 > WIN_W) ? SLOT_W + 1 : WIN_W;  // compare width
    localparam int CNT_W  = $clog2(SUM_W);

    // Sequencer and filter state
    bma_state_t                  state_reg, state_next;
    logic [WIN_W-1:0]            window_reg, window_next;
    logic [WIN_W-1:0]            fill_reg, fill_next;
    logic [SLOT_W-1:0]           slot_reg, slot_next;
    logic signed [SUM_W-1:0]     sum_reg, sum_next;

    // Per-transaction payload
    logic signed [SAMPLE_W-1:0]  sample_reg;
    logic signed [SAMPLE_W-1:0]  old_reg;          // history slot about to be overwritten

    // Divider: remainder, dividend/quotient shifter, bit counter
    logic [WIN_W-1:0]            rem_reg, rem_next;
    logic [SUM_W-1:0]            quo_reg, quo_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        neg_reg, neg_next;

    // Output register
    logic                        out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]         out_data_reg, out_data_next;

    // History RAM
    logic signed [SAMPLE_W-1:0]  hist_mem [MAX_WINDOW];

    // Datapath helpers
    logic                        s_accept;
    logic                        cfg_accept;
    logic                        full;
    logic signed [SUM_W-1:0]     sum_upd;
    logic [SUM_W-1:0]            sum_mag;
    logic [WIN_W-1:0]            fill_upd;
    logic [WIN_W:0]              trial;
    logic                        trial_ge;
    logic [WIN_W-1:0]            cfg_win;

    assign cfg_ready  = (state_reg == ST_IDLE);
    assign s_tready   = (state_reg == ST_IDLE) && !cfg_valid;   // config wins a tie
    assign cfg_accept = cfg_valid && cfg_ready;
    assign s_accept   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Window is full once fill count has reached window size; then the
    // oldest sample leaves the running sum as the new one enters.
    assign full     = (fill_reg == window_reg);
    assign sum_upd  = sum_reg - (full ? SUM_W'(old_reg) : SUM_W'(0)) + SUM_W'(sample_reg);
    assign sum_mag  = sum_upd[SUM_W-1] ? SUM_W'(-sum_upd) : SUM_W'(sum_upd);
    assign fill_upd = full ? fill_reg : fill_reg + WIN_W'(1);

    // Restoring divide step: shift one dividend bit into the remainder
    assign trial    = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_ge = (trial >= {1'b0, window_reg});

    // Clamp the written window to 1..MAX_WINDOW
    always_comb begin
        cfg_win = cfg_data;
        if (cfg_data == '0) begin
            cfg_win = WIN_W'(1);
        end else if (int'(cfg_data) > MAX_WINDOW) begin
            cfg_win = WIN_W'(MAX_WINDOW);
        end
    end

    always_comb begin
        state_next     = state_reg;
        window_next    = window_reg;
        fill_next      = fill_reg;
        slot_next      = slot_reg;
        sum_next       = sum_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        // Output transaction frees the register
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (cfg_accept) begin
                    // New window restarts the filter
                    window_next = cfg_win;
                    fill_next   = '0;
                    slot_next   = '0;
                    sum_next    = '0;
                end else if (s_accept) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                sum_next  = sum_upd;
                fill_next = fill_upd;
                if (CW'(slot_reg) + CW'(1) == CW'(window_reg)) begin
                    slot_next = '0;
                end else begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
                if (fill_upd == window_reg) begin
                    // Divide |sum| by window, fix sign at the end
                    neg_next   = sum_upd[SUM_W-1];
                    rem_next   = '0;
                    quo_next   = sum_mag;
                    cnt_next   = CNT_W'(SUM_W - 1);
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                rem_next = trial_ge ? WIN_W'(trial - {1'b0, window_reg}) : trial[WIN_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], trial_ge};
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_DONE: begin
                // Wait for the output register to drain
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = neg_reg ? SAMPLE_W'(-quo_reg[SAMPLE_W-1:0])
                                             : quo_reg[SAMPLE_W-1:0];
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            window_reg    <= WIN_W'(1);
            fill_reg      <= '0;
            slot_reg      <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            fill_reg      <= fill_next;
            slot_reg      <= slot_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            sample_reg <= signed'(s_tdata);
        end
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
    end

    // History RAM: read of the outgoing slot at accept, write of the new sample in UPDATE
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            old_reg <= hist_mem[slot_reg];
        end
        if (state_reg == ST_UPDATE) begin
            hist_mem[slot_reg] <= sample_reg;
        end
    end

    // Fill count saturates at the window size
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= window_reg)
        else $error("fill count above window size");

    // Write slot always inside the active window
    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CW'(slot_reg) < CW'(window_reg))
        else $error("write slot outside window");

    // Window register stays within 1..MAX_WINDOW
    a_window_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (window_reg != '0) && (int'(window_reg) <= MAX_WINDOW))
        else $error("window size out of range");

    // A divide only runs with a full window
    a_div_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (fill_reg == window_reg))
        else $error("divide started before window full");

endmodule

`default_nettype wire
